// ----- rtl/z85_pkg.sv -----
// Shared constants, types and lookup tables for the Z85 tuple codec.
`default_nettype none

package z85_pkg;

  // Field widths and lane count
  localparam int Z85_LANES      = 5;
  localparam int Z85_WORD_W     = 32;
  localparam int Z85_CHAR_W     = 8;
  localparam int Z85_DIGIT_W    = 7;
  localparam int Z85_CHAR_CODES = 1 << Z85_CHAR_W;
  localparam int Z85_DIGIT_CODES = 1 << Z85_DIGIT_W;

  // Radix and character range
  localparam int Z85_RADIX      = 85;
  localparam logic [Z85_CHAR_W-1:0] Z85_NO_DIGIT = 8'hFF;
  localparam int Z85_FIRST_CODE = 32;
  localparam int Z85_CODE_SPAN  = 96;

  // Alphabet, first character in the top byte
  localparam logic [Z85_RADIX*Z85_CHAR_W-1:0] Z85_ALPHABET =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } z85_cmd_t;

  // Stage enables for the lane stages and the merge stages
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } z85_lane_ctl_t;

  typedef struct packed {
    logic en4;
    logic en5;
  } z85_merge_ctl_t;

  typedef logic [Z85_CHAR_W-1:0] z85_dig_tab_t [Z85_CHAR_CODES];
  typedef logic [Z85_CHAR_W-1:0] z85_chr_tab_t [Z85_DIGIT_CODES];

  // 85 to the power n
  function automatic logic [63:0] z85_pow(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'(Z85_RADIX);
    end
    return p;
  endfunction

  // Character code -> digit value, NO_DIGIT outside the alphabet
  function automatic z85_dig_tab_t z85_build_dig();
    z85_dig_tab_t tab;
    logic [Z85_CHAR_W-1:0] code;
    for (int c = 0; c < Z85_CHAR_CODES; c++) begin
      tab[c] = Z85_NO_DIGIT;
    end
    for (int k = 0; k < Z85_RADIX; k++) begin
      code = Z85_ALPHABET[(Z85_RADIX-1-k)*Z85_CHAR_W +: Z85_CHAR_W];
      if (int'(code) >= Z85_FIRST_CODE && int'(code) < Z85_FIRST_CODE + Z85_CODE_SPAN) begin
        tab[code] = Z85_CHAR_W'(k);
      end
    end
    return tab;
  endfunction

  // Digit value -> character code; unused digit codes give zero
  function automatic z85_chr_tab_t z85_build_chr();
    z85_chr_tab_t tab;
    for (int d = 0; d < Z85_DIGIT_CODES; d++) begin
      if (d < Z85_RADIX) begin
        tab[d] = Z85_ALPHABET[(Z85_RADIX-1-d)*Z85_CHAR_W +: Z85_CHAR_W];
      end else begin
        tab[d] = '0;
      end
    end
    return tab;
  endfunction

  localparam z85_dig_tab_t Z85_DIGIT_TAB = z85_build_dig();
  localparam z85_chr_tab_t Z85_CHAR_TAB  = z85_build_chr();

endpackage

`default_nettype wire

// ----- rtl/z85_tuple_codec.sv -----
// Top level of the Z85 tuple codec: handshake, stage control and lanes.
//
// Z85 tuple codec. Each item is one encode (32-bit word to five alphabet
// characters, most significant first) or one decode (five characters to a
// 32-bit word, wrapping modulo 2^32; a character outside the alphabet sets
// bad_char and zeroes the word). The block takes one item per clock unless
// a stalled result holds it back, and offers its result through five register
// stages: three lane stages
// (reciprocal multiply by 1/85^k, quotient estimate, one-step correction,
// with the decode digit lookup and weighting alongside) and two merge stages
// (digit extraction and first adder level, then character lookup, final sum
// and the output register). Stages advance independently, so empty stages
// fill while out_stall is high. No state survives an item and there is no
// configuration.
`default_nettype none

module z85_tuple_codec (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic [z85_pkg::Z85_WORD_W-1:0]  in_data_word,
  input  logic [z85_pkg::Z85_CHAR_W-1:0]  in_char0,
  input  logic [z85_pkg::Z85_CHAR_W-1:0]  in_char1,
  input  logic [z85_pkg::Z85_CHAR_W-1:0]  in_char2,
  input  logic [z85_pkg::Z85_CHAR_W-1:0]  in_char3,
  input  logic [z85_pkg::Z85_CHAR_W-1:0]  in_char4,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [z85_pkg::Z85_WORD_W-1:0]  out_result_word,
  output logic [z85_pkg::Z85_CHAR_W-1:0]  out_char0,
  output logic [z85_pkg::Z85_CHAR_W-1:0]  out_char1,
  output logic [z85_pkg::Z85_CHAR_W-1:0]  out_char2,
  output logic [z85_pkg::Z85_CHAR_W-1:0]  out_char3,
  output logic [z85_pkg::Z85_CHAR_W-1:0]  out_char4,
  output logic                            out_bad_char
);
  import z85_pkg::*;

  z85_lane_ctl_t  lane_ctl;
  z85_merge_ctl_t merge_ctl;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;
  logic cmd1_r, cmd2_r, cmd3_r;

  logic [Z85_CHAR_W-1:0] in_chars [Z85_LANES];
  logic [Z85_WORD_W-1:0] quot     [Z85_LANES];
  logic [Z85_WORD_W-1:0] term     [Z85_LANES];
  logic                  bad      [Z85_LANES];
  logic [Z85_CHAR_W-1:0] chars    [Z85_LANES];

  // A stage may load when it is empty or its successor loads
  assign en5 = !v5_r || !out_stall;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_stall  = !en1;
  assign out_valid = v5_r;

  assign lane_ctl  = '{en1: en1, en2: en2, en3: en3};
  assign merge_ctl = '{en4: en4, en5: en5};

  // Item valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // Command travels alongside the lane stages
  always_ff @(posedge clk) begin
    if (en1) cmd1_r <= in_command;
    if (en2) cmd2_r <= cmd1_r;
    if (en3) cmd3_r <= cmd2_r;
  end

  assign in_chars[0] = in_char0;
  assign in_chars[1] = in_char1;
  assign in_chars[2] = in_char2;
  assign in_chars[3] = in_char3;
  assign in_chars[4] = in_char4;

  // Lane k: divide by 85^k; decode the character of weight 85^k
  generate
    for (genvar k = 0; k < Z85_LANES; k++) begin : g_lane
      z85_lane #(
        .LANE_IDX (k)
      ) u_lane (
        .clk       (clk),
        .ctl       (lane_ctl),
        .data_word (in_data_word),
        .code      (in_chars[Z85_LANES-1-k]),
        .quot      (quot[k]),
        .term      (term[k]),
        .bad       (bad[k])
      );
    end
  endgenerate

  z85_merge u_merge (
    .clk         (clk),
    .ctl         (merge_ctl),
    .cmd         (cmd3_r),
    .quot        (quot),
    .term        (term),
    .bad         (bad),
    .result_word (out_result_word),
    .chars       (chars),
    .bad_char    (out_bad_char)
  );

  assign out_char0 = chars[0];
  assign out_char1 = chars[1];
  assign out_char2 = chars[2];
  assign out_char3 = chars[3];
  assign out_char4 = chars[4];

endmodule

`default_nettype wire

// ----- rtl/z85_lane.sv -----
// One Z85 lane: quotient by 85^k for encode, weighted digit for decode.
`default_nettype none

module z85_lane #(
  parameter int LANE_IDX = 0
) (
  input  logic                             clk,
  input  z85_pkg::z85_lane_ctl_t           ctl,
  input  logic [z85_pkg::Z85_WORD_W-1:0]   data_word,
  input  logic [z85_pkg::Z85_CHAR_W-1:0]   code,
  output logic [z85_pkg::Z85_WORD_W-1:0]   quot,
  output logic [z85_pkg::Z85_WORD_W-1:0]   term,
  output logic                             bad
);
  import z85_pkg::*;

  localparam logic [63:0] DIVISOR = z85_pow(LANE_IDX);
  localparam int          SHIFT_L = $clog2(DIVISOR + 64'd1) - 1;
  localparam logic [63:0] RECIP   = (64'd1 << (Z85_WORD_W + SHIFT_L)) / DIVISOR;
  localparam logic [Z85_WORD_W-1:0] DIV_W  = DIVISOR[Z85_WORD_W-1:0];
  localparam logic [Z85_WORD_W-1:0] WEIGHT = DIVISOR[Z85_WORD_W-1:0];

  // Decode side: digit lookup and weight, wraps modulo 2^32
  logic [Z85_CHAR_W-1:0]  dig;
  logic [Z85_DIGIT_W-1:0] dig_val;
  logic                   bad1_nxt;
  logic [Z85_WORD_W-1:0]  term1_nxt;
  logic [Z85_WORD_W-1:0]  term1_r, term2_r, term3_r;
  logic                   bad1_r, bad2_r, bad3_r;

  assign dig       = Z85_DIGIT_TAB[code];
  assign bad1_nxt  = (dig == Z85_NO_DIGIT);
  assign dig_val   = bad1_nxt ? '0 : dig[Z85_DIGIT_W-1:0];
  assign term1_nxt = Z85_WORD_W'(dig_val) * WEIGHT;

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      term1_r <= term1_nxt;
      bad1_r  <= bad1_nxt;
    end
    if (ctl.en2) begin
      term2_r <= term1_r;
      bad2_r  <= bad1_r;
    end
    if (ctl.en3) begin
      term3_r <= term2_r;
      bad3_r  <= bad2_r;
    end
  end

  assign term = term3_r;
  assign bad  = bad3_r;

  // Encode side: floor(data_word / 85^k)
  generate
    if (LANE_IDX == 0) begin : g_pass
      logic [Z85_WORD_W-1:0] word1_r, word2_r, word3_r;

      always_ff @(posedge clk) begin
        if (ctl.en1) word1_r <= data_word;
        if (ctl.en2) word2_r <= word1_r;
        if (ctl.en3) word3_r <= word2_r;
      end

      assign quot = word3_r;
    end else begin : g_div
      logic [2*Z85_WORD_W-1:0] prod1_r;
      logic [Z85_WORD_W-1:0]   word1_r, word2_r;
      logic [Z85_WORD_W-1:0]   qest2_nxt, qest2_r;
      logic [Z85_WORD_W-1:0]   rem;
      logic [Z85_WORD_W-1:0]   quot3_nxt, quot3_r;

      // Reciprocal estimate, low by at most one
      assign qest2_nxt = Z85_WORD_W'(prod1_r >> (Z85_WORD_W + SHIFT_L));

      // One compare-and-add correction
      assign rem       = word2_r - qest2_r * DIV_W;
      assign quot3_nxt = qest2_r + Z85_WORD_W'(rem >= DIV_W);

      always_ff @(posedge clk) begin
        if (ctl.en1) begin
          prod1_r <= (2*Z85_WORD_W)'(data_word) * (2*Z85_WORD_W)'(RECIP[Z85_WORD_W-1:0]);
          word1_r <= data_word;
        end
        if (ctl.en2) begin
          qest2_r <= qest2_nxt;
          word2_r <= word1_r;
        end
        if (ctl.en3) begin
          quot3_r <= quot3_nxt;
        end
      end

      assign quot = quot3_r;
    end
  endgenerate

endmodule

`default_nettype wire

// ----- rtl/z85_merge.sv -----
// Merge stages: digits and characters for encode, summed word for decode.
`default_nettype none

module z85_merge (
  input  logic                             clk,
  input  z85_pkg::z85_merge_ctl_t          ctl,
  input  logic                             cmd,
  input  logic [z85_pkg::Z85_WORD_W-1:0]   quot [z85_pkg::Z85_LANES],
  input  logic [z85_pkg::Z85_WORD_W-1:0]   term [z85_pkg::Z85_LANES],
  input  logic                             bad  [z85_pkg::Z85_LANES],
  output logic [z85_pkg::Z85_WORD_W-1:0]   result_word,
  output logic [z85_pkg::Z85_CHAR_W-1:0]   chars [z85_pkg::Z85_LANES],
  output logic                             bad_char
);
  import z85_pkg::*;

  logic [Z85_WORD_W-1:0]  diff [Z85_LANES];
  logic [Z85_DIGIT_W-1:0] digit4_r [Z85_LANES];
  logic [Z85_WORD_W-1:0]  s01_nxt, s23_nxt;
  logic [Z85_WORD_W-1:0]  s01_r, s23_r, t4_r;
  logic                   bad4_nxt, bad4_r;
  logic                   cmd4_r;
  logic [Z85_WORD_W-1:0]  word5_nxt, word5_r;
  logic                   bad5_r;
  logic [Z85_CHAR_W-1:0]  char5_r [Z85_LANES];

  // Digit k = q_k - 85 * q_(k+1); the top quotient is already a digit
  always_comb begin
    for (int k = 0; k < Z85_LANES; k++) begin
      if (k == Z85_LANES - 1) begin
        diff[k] = quot[k];
      end else begin
        diff[k] = quot[k] - quot[k+1] * Z85_WORD_W'(Z85_RADIX);
      end
    end
  end

  // Decode: first level of the term adder tree
  assign s01_nxt  = term[0] + term[1];
  assign s23_nxt  = term[2] + term[3];
  assign bad4_nxt = bad[0] | bad[1] | bad[2] | bad[3] | bad[4];

  always_ff @(posedge clk) begin
    if (ctl.en4) begin
      for (int k = 0; k < Z85_LANES; k++) begin
        digit4_r[k] <= diff[k][Z85_DIGIT_W-1:0];
      end
      s01_r  <= s01_nxt;
      s23_r  <= s23_nxt;
      t4_r   <= term[4];
      bad4_r <= bad4_nxt;
      cmd4_r <= cmd;
    end
  end

  // Output register; unused side of the result reads as zero
  assign word5_nxt = s01_r + s23_r + t4_r;

  always_ff @(posedge clk) begin
    if (ctl.en5) begin
      word5_r <= (cmd4_r == CMD_DECODE && !bad4_r) ? word5_nxt : '0;
      bad5_r  <= (cmd4_r == CMD_DECODE) && bad4_r;
      for (int j = 0; j < Z85_LANES; j++) begin
        char5_r[j] <= (cmd4_r == CMD_ENCODE) ? Z85_CHAR_TAB[digit4_r[Z85_LANES-1-j]] : '0;
      end
    end
  end

  assign result_word = word5_r;
  assign chars       = char5_r;
  assign bad_char    = bad5_r;

endmodule

`default_nettype wire

// ----- rtl/z85_checker.sv -----
// Port-level checks for the Z85 tuple codec and their bind.
`default_nettype none

module z85_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [z85_pkg::Z85_WORD_W-1:0]  out_result_word,
  input logic [z85_pkg::Z85_CHAR_W-1:0]  out_char0,
  input logic [z85_pkg::Z85_CHAR_W-1:0]  out_char1,
  input logic [z85_pkg::Z85_CHAR_W-1:0]  out_char2,
  input logic [z85_pkg::Z85_CHAR_W-1:0]  out_char3,
  input logic [z85_pkg::Z85_CHAR_W-1:0]  out_char4,
  input logic                            out_bad_char
);

  // A stalled result item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // A stalled result item keeps its word, first and last characters and bad_char
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result_word) && $stable(out_char0)
      && $stable(out_char4) && $stable(out_bad_char))
    else $error("result payload changed while stalled");

  // An input item waits only behind a stalled result
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled with no stalled result");

  // A bad character always zeroes the word
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_char |-> out_result_word == '0)
    else $error("bad_char with nonzero word");

  // Encode results carry five alphabet characters and no word
  a_encode_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char0 != '0 |-> out_result_word == '0 && !out_bad_char
      && out_char1 != '0 && out_char2 != '0 && out_char3 != '0 && out_char4 != '0)
    else $error("mixed encode and decode fields");

endmodule

bind z85_tuple_codec z85_checker u_z85_checker (.*);

`default_nettype wire
